// ===== rtl/fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Flow metering table package
// Shared types, constants and codes for the flow metering table.
// ----------------------------------------------------------------------------
`default_nettype none

package fmt_pkg;

  localparam int unsigned EntriesPerDirDefault = 256;

  localparam logic [31:0] HashKSrcAddr = 32'hef6e15aa;
  localparam logic [31:0] HashKDstAddr = 32'h65cd52a0;
  localparam logic [31:0] HashKSrcPort = 32'h00008216;
  localparam logic [31:0] HashKDstPort = 32'h000dda37;
  localparam logic [31:0] HashKProto   = 32'h0000bc06;

  typedef enum logic [2:0] {
    HSEL_SRC_ADDR = 3'd0,
    HSEL_DST_ADDR = 3'd1,
    HSEL_SRC_PORT = 3'd2,
    HSEL_DST_PORT = 3'd3,
    HSEL_PROTO    = 3'd4
  } hash_sel_e;

  typedef enum logic [1:0] {
    STATUS_CREATED = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_APPLY
  } ctrl_state_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  protocol;
    logic [15:0] packet_length;
    logic [7:0]  tcp_flag_bits;
    logic [7:0]  type_of_service;
    logic [7:0]  icmp_mix;
    logic [7:0]  time_to_live;
    logic        direction;
    logic [63:0] timestamp;
  } pkt_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flow_hash;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [63:0] start_time;
    logic [63:0] end_time;
    logic [7:0]  flag_union;
    logic [7:0]  tos_union;
    logic [7:0]  icmp_union;
    logic [7:0]  lowest_ttl;
    logic [7:0]  highest_ttl;
  } res_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [63:0] start;
    logic [63:0] last;
    logic [7:0]  flags;
    logic [7:0]  tos;
    logic [7:0]  icmp;
    logic [7:0]  min_ttl;
    logic [7:0]  max_ttl;
  } entry_t;

  typedef struct packed {
    logic      load;
    logic      hash_en;
    hash_sel_e hash_sel;
    logic      scan_start;
    logic      scan_run;
    logic      apply;
  } cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/fmt_if.sv =====
// ----------------------------------------------------------------------------
// Flow metering table channels
// Valid/ready channels for packet words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmt_pkt_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  protocol;
  logic [15:0] packet_length;
  logic [7:0]  tcp_flag_bits;
  logic [7:0]  type_of_service;
  logic [7:0]  icmp_mix;
  logic [7:0]  time_to_live;
  logic        direction;
  logic [63:0] timestamp;

  modport source (
    output valid, src_addr, dst_addr, src_port, dst_port, protocol, packet_length,
           tcp_flag_bits, type_of_service, icmp_mix, time_to_live, direction, timestamp,
    input  ready
  );
  modport sink (
    input  valid, src_addr, dst_addr, src_port, dst_port, protocol, packet_length,
           tcp_flag_bits, type_of_service, icmp_mix, time_to_live, direction, timestamp,
    output ready
  );
endinterface

interface fmt_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] flow_hash;
  logic [31:0] packet_total;
  logic [47:0] byte_total;
  logic [63:0] start_time;
  logic [63:0] end_time;
  logic [7:0]  flag_union;
  logic [7:0]  tos_union;
  logic [7:0]  icmp_union;
  logic [7:0]  lowest_ttl;
  logic [7:0]  highest_ttl;

  modport source (
    output valid, status, flow_hash, packet_total, byte_total, start_time, end_time,
           flag_union, tos_union, icmp_union, lowest_ttl, highest_ttl,
    input  ready
  );
  modport sink (
    input  valid, status, flow_hash, packet_total, byte_total, start_time, end_time,
           flag_union, tos_union, icmp_union, lowest_ttl, highest_ttl,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/fmt_ram.sv =====
// ----------------------------------------------------------------------------
// Flow metering table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/fmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Flow metering table controller
// Sequences hashing, table search and entry update for one packet.
// ----------------------------------------------------------------------------
`default_nettype none

module fmt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output fmt_pkg::cmd_t      cmd_o,
  input  wire fmt_pkg::stat_t stat_i
);

  fmt_pkg::ctrl_state_e state_q, state_d;
  fmt_pkg::hash_sel_e   sel_q, sel_d;
  logic                 out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fmt_pkg::ST_IDLE;
      sel_q     <= fmt_pkg::HSEL_SRC_ADDR;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    cmd_o      = '0;
    cmd_o.hash_sel = sel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      fmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d      = fmt_pkg::HSEL_SRC_ADDR;
          state_d    = fmt_pkg::ST_HASH;
        end
      end
      fmt_pkg::ST_HASH: begin
        cmd_o.hash_en = 1'b1;
        unique case (sel_q)
          fmt_pkg::HSEL_SRC_ADDR: sel_d = fmt_pkg::HSEL_DST_ADDR;
          fmt_pkg::HSEL_DST_ADDR: sel_d = fmt_pkg::HSEL_SRC_PORT;
          fmt_pkg::HSEL_SRC_PORT: sel_d = fmt_pkg::HSEL_DST_PORT;
          fmt_pkg::HSEL_DST_PORT: sel_d = fmt_pkg::HSEL_PROTO;
          default: begin
            cmd_o.scan_start = 1'b1;
            state_d          = fmt_pkg::ST_SCAN;
          end
        endcase
      end
      fmt_pkg::ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (stat_i.scan_hit || stat_i.scan_miss) begin
          state_d = fmt_pkg::ST_APPLY;
        end
      end
      fmt_pkg::ST_APPLY: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.apply = 1'b1;
          out_vld_d   = 1'b1;
          state_d     = fmt_pkg::ST_IDLE;
        end
      end
      default: state_d = fmt_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_vld_q;

  a_apply_only_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> $past(state_q) == fmt_pkg::ST_SCAN || $past(state_q) == fmt_pkg::ST_APPLY)
    else $error("entry update without a finished search");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && !$past(cmd_o.apply))
    else $error("pending result overwritten");
  a_hit_miss_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat_i.scan_hit && stat_i.scan_miss))
    else $error("search reports hit and miss together");

endmodule

`default_nettype wire

// ===== rtl/fmt_dp.sv =====
// ----------------------------------------------------------------------------
// Flow metering table datapath
// Hash unit, per-direction fill counts, entry RAM search and update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module fmt_dp #(
  parameter int unsigned EntriesPerDir = fmt_pkg::EntriesPerDirDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fmt_pkg::pkt_t  pkt_i,
  input  wire fmt_pkg::cmd_t  cmd_i,
  output fmt_pkg::stat_t      stat_o,
  output fmt_pkg::res_t       res_o
);

  localparam int unsigned Depth = 2 * EntriesPerDir;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned IdxW  = (EntriesPerDir > 1) ? $clog2(EntriesPerDir) : 1;
  localparam int unsigned CntW  = $clog2(EntriesPerDir + 1);
  localparam int unsigned EntW  = $bits(fmt_pkg::entry_t);

  fmt_pkg::pkt_t   pkt_q;
  fmt_pkg::res_t   res_q, res_d;
  fmt_pkg::entry_t ent_q, rd_ent, upd_ent;
  logic [31:0]     hash_q, mul_a, mul_k;
  logic [31:0]     prod;
  logic [CntW-1:0] fill_q [2];
  logic [CntW-1:0] fill_sel, rd_idx_q, cmp_idx_q, hit_idx_q, wr_idx;
  logic            cmp_vld_q, hit_q, scan_hit, scan_miss, issue, full;
  logic [AddrW-1:0] raddr, waddr;
  logic [EntW-1:0] rdata;
  logic            we;
  logic [48:0]     byte_sum;

  assign fill_sel = fill_q[pkt_q.direction];
  assign full     = (fill_sel == CntW'(EntriesPerDir));

  always_comb begin
    mul_a = '0;
    mul_k = '0;
    case (cmd_i.hash_sel)
      fmt_pkg::HSEL_SRC_ADDR: begin mul_a = pkt_q.src_addr; mul_k = fmt_pkg::HashKSrcAddr; end
      fmt_pkg::HSEL_DST_ADDR: begin mul_a = pkt_q.dst_addr; mul_k = fmt_pkg::HashKDstAddr; end
      fmt_pkg::HSEL_SRC_PORT: begin
        mul_a = {16'd0, pkt_q.src_port};
        mul_k = fmt_pkg::HashKSrcPort;
      end
      fmt_pkg::HSEL_DST_PORT: begin
        mul_a = {16'd0, pkt_q.dst_port};
        mul_k = fmt_pkg::HashKDstPort;
      end
      fmt_pkg::HSEL_PROTO: begin mul_a = {24'd0, pkt_q.protocol}; mul_k = fmt_pkg::HashKProto; end
      default: begin mul_a = '0; mul_k = '0; end
    endcase
  end

  assign prod = 32'(mul_a * mul_k);

  function automatic logic [AddrW-1:0] entry_addr(input logic dir, input logic [CntW-1:0] idx);
    logic [AddrW-1:0] base;
    base = dir ? AddrW'(EntriesPerDir) : '0;
    return base + AddrW'(idx[IdxW-1:0]);
  endfunction

  assign rd_ent    = fmt_pkg::entry_t'(rdata);
  assign scan_hit  = cmd_i.scan_run && cmp_vld_q && (rd_ent.tag == hash_q);
  assign scan_miss = cmd_i.scan_run && !cmp_vld_q && (rd_idx_q == fill_sel);
  assign issue     = cmd_i.scan_run && !scan_hit && (rd_idx_q != fill_sel);
  assign raddr     = entry_addr(pkt_q.direction, rd_idx_q);
  assign stat_o.scan_hit  = scan_hit;
  assign stat_o.scan_miss = scan_miss;

  always_comb begin
    byte_sum = {1'b0, ent_q.bytes} + 49'(pkt_q.packet_length);
    upd_ent  = ent_q;
    res_d    = '0;
    res_d.flow_hash = hash_q;
    wr_idx   = hit_idx_q;
    we       = 1'b0;
    if (hit_q) begin
      upd_ent.packets = (ent_q.packets == '1) ? ent_q.packets : ent_q.packets + 32'd1;
      upd_ent.bytes   = byte_sum[48] ? '1 : byte_sum[47:0];
      upd_ent.last    = pkt_q.timestamp;
      upd_ent.flags   = ent_q.flags | pkt_q.tcp_flag_bits;
      upd_ent.tos     = ent_q.tos | pkt_q.type_of_service;
      upd_ent.icmp    = ent_q.icmp | pkt_q.icmp_mix;
      if (pkt_q.time_to_live < ent_q.min_ttl) upd_ent.min_ttl = pkt_q.time_to_live;
      if (pkt_q.time_to_live > ent_q.max_ttl) upd_ent.max_ttl = pkt_q.time_to_live;
      res_d.status = fmt_pkg::STATUS_UPDATED;
      we = cmd_i.apply;
    end else begin
      upd_ent.tag     = hash_q;
      upd_ent.packets = 32'd1;
      upd_ent.bytes   = 48'(pkt_q.packet_length);
      upd_ent.start   = pkt_q.timestamp;
      upd_ent.last    = pkt_q.timestamp;
      upd_ent.flags   = pkt_q.tcp_flag_bits;
      upd_ent.tos     = pkt_q.type_of_service;
      upd_ent.icmp    = pkt_q.icmp_mix;
      upd_ent.min_ttl = pkt_q.time_to_live;
      upd_ent.max_ttl = pkt_q.time_to_live;
      wr_idx = fill_sel;
      res_d.status = full ? fmt_pkg::STATUS_DROPPED : fmt_pkg::STATUS_CREATED;
      we = cmd_i.apply && !full;
    end
    if (res_d.status != fmt_pkg::STATUS_DROPPED) begin
      res_d.packet_total = upd_ent.packets;
      res_d.byte_total   = upd_ent.bytes;
      res_d.start_time   = upd_ent.start;
      res_d.end_time     = upd_ent.last;
      res_d.flag_union   = upd_ent.flags;
      res_d.tos_union    = upd_ent.tos;
      res_d.icmp_union   = upd_ent.icmp;
      res_d.lowest_ttl   = upd_ent.min_ttl;
      res_d.highest_ttl  = upd_ent.max_ttl;
    end
  end

  assign waddr = entry_addr(pkt_q.direction, wr_idx);

  fmt_ram #(
    .Width(EntW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(upd_ent),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pkt_q <= pkt_i;
    end
    if (cmd_i.load) begin
      hash_q <= '0;
    end else if (cmd_i.hash_en) begin
      hash_q <= hash_q ^ prod;
    end
    if (scan_hit) begin
      ent_q     <= rd_ent;
      hit_idx_q <= cmp_idx_q;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q;
    end
    if (cmd_i.apply) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0] <= '0;
      fill_q[1] <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        rd_idx_q  <= '0;
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        cmp_vld_q <= issue;
        if (issue) rd_idx_q <= rd_idx_q + CntW'(1);
        if (scan_hit) hit_q <= 1'b1;
      end
      if (cmd_i.apply && !hit_q && !full) begin
        fill_q[pkt_q.direction] <= fill_sel + CntW'(1);
      end
    end
  end

  assign res_o = res_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q[0] <= CntW'(EntriesPerDir) && fill_q[1] <= CntW'(EntriesPerDir))
    else $error("fill count beyond table size");
  a_create_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && !hit_q && !full |=> fill_sel == $past(fill_sel) + CntW'(1))
    else $error("created entry did not advance fill count");
  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_run |-> rd_idx_q <= fill_sel)
    else $error("search ran past filled entries");

endmodule

`default_nettype wire

// ===== rtl/flow_metering_table.sv =====
// ----------------------------------------------------------------------------
// Flow metering table
// Per-direction flow cache keyed by a multiplicative 5-tuple hash.
// ----------------------------------------------------------------------------
// Each packet word is hashed with one 32x32 multiply per tuple field, then the
// entry RAM is searched at one entry per cycle over the filled entries of its
// direction (0 to EntriesPerDir), and the entry found is updated or a new one
// is created, or the packet is dropped when that direction is full. The search
// length is set by the single read port of the entry RAM. Entries are allocated
// in order and never freed, so a fill count per direction replaces valid bits
// and no clearing pass is needed after reset. A finished result waits in an
// output register while the next packet word is taken and processed.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_metering_table #(
  parameter int unsigned EntriesPerDir = fmt_pkg::EntriesPerDirDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fmt_pkt_if.sink   pkt_i,
  fmt_res_if.source res_o
);

  fmt_pkg::cmd_t  cmd;
  fmt_pkg::stat_t stat;
  fmt_pkg::pkt_t  pkt;
  fmt_pkg::res_t  res;

  assign pkt.src_addr        = pkt_i.src_addr;
  assign pkt.dst_addr        = pkt_i.dst_addr;
  assign pkt.src_port        = pkt_i.src_port;
  assign pkt.dst_port        = pkt_i.dst_port;
  assign pkt.protocol        = pkt_i.protocol;
  assign pkt.packet_length   = pkt_i.packet_length;
  assign pkt.tcp_flag_bits   = pkt_i.tcp_flag_bits;
  assign pkt.type_of_service = pkt_i.type_of_service;
  assign pkt.icmp_mix        = pkt_i.icmp_mix;
  assign pkt.time_to_live    = pkt_i.time_to_live;
  assign pkt.direction       = pkt_i.direction;
  assign pkt.timestamp       = pkt_i.timestamp;

  fmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_ready_o (pkt_i.ready),
    .out_valid_o(res_o.valid),
    .out_ready_i(res_o.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  fmt_dp #(
    .EntriesPerDir(EntriesPerDir)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (res)
  );

  assign res_o.status       = res.status;
  assign res_o.flow_hash    = res.flow_hash;
  assign res_o.packet_total = res.packet_total;
  assign res_o.byte_total   = res.byte_total;
  assign res_o.start_time   = res.start_time;
  assign res_o.end_time     = res.end_time;
  assign res_o.flag_union   = res.flag_union;
  assign res_o.tos_union    = res.tos_union;
  assign res_o.icmp_union   = res.icmp_union;
  assign res_o.lowest_ttl   = res.lowest_ttl;
  assign res_o.highest_ttl  = res.highest_ttl;

endmodule

`default_nettype wire

// ===== test/fmt_checker.sv =====
// ----------------------------------------------------------------------------
// Flow metering table checker
// Watches the packet and result channels, keeps its own copy of both flow
// tables, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module fmt_checker #(
  parameter int unsigned EntriesPerDir = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fmt_pkt_if.sink     pkt_mon,
  fmt_res_if.sink     res_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import fmt_pkg::*;

  entry_t      flows [2][EntriesPerDir];
  int unsigned fill [2];
  res_t        expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] tuple_hash(pkt_t p);
    logic [31:0] h;
    h = p.src_addr * HashKSrcAddr;
    h ^= p.dst_addr * HashKDstAddr;
    h ^= {16'd0, p.src_port} * HashKSrcPort;
    h ^= {16'd0, p.dst_port} * HashKDstPort;
    h ^= {24'd0, p.protocol} * HashKProto;
    return h;
  endfunction

  task automatic meter_packet(pkt_t p);
    res_t        r;
    logic [31:0] h;
    int          d;
    int          hit;
    logic [48:0] sum;
    h = tuple_hash(p);
    d = p.direction;
    hit = -1;
    r = '0;
    r.flow_hash = h;
    for (int i = 0; i < fill[d]; i++) begin
      if (flows[d][i].tag == h) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      if (flows[d][hit].packets != '1) flows[d][hit].packets++;
      sum = {1'b0, flows[d][hit].bytes} + 49'(p.packet_length);
      flows[d][hit].bytes = sum[48] ? '1 : sum[47:0];
      flows[d][hit].last = p.timestamp;
      flows[d][hit].flags |= p.tcp_flag_bits;
      flows[d][hit].tos |= p.type_of_service;
      flows[d][hit].icmp |= p.icmp_mix;
      if (p.time_to_live > flows[d][hit].max_ttl) flows[d][hit].max_ttl = p.time_to_live;
      if (p.time_to_live < flows[d][hit].min_ttl) flows[d][hit].min_ttl = p.time_to_live;
      r.status = STATUS_UPDATED;
    end else if (fill[d] < EntriesPerDir) begin
      hit = fill[d];
      fill[d]++;
      flows[d][hit] = '{tag: h, packets: 32'd1, bytes: 48'(p.packet_length),
                        start: p.timestamp, last: p.timestamp, flags: p.tcp_flag_bits,
                        tos: p.type_of_service, icmp: p.icmp_mix,
                        min_ttl: p.time_to_live, max_ttl: p.time_to_live};
      r.status = STATUS_CREATED;
    end else begin
      r.status = STATUS_DROPPED;
    end
    if (hit >= 0) begin
      r.packet_total = flows[d][hit].packets;
      r.byte_total = flows[d][hit].bytes;
      r.start_time = flows[d][hit].start;
      r.end_time = flows[d][hit].last;
      r.flag_union = flows[d][hit].flags;
      r.tos_union = flows[d][hit].tos;
      r.icmp_union = flows[d][hit].icmp;
      r.lowest_ttl = flows[d][hit].min_ttl;
      r.highest_ttl = flows[d][hit].max_ttl;
    end
    expected_q.push_back(r);
  endtask

  task automatic compare_result(res_t got);
    res_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      fail_count_o++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      fail_count_o++;
    end
    if (got.flow_hash !== want.flow_hash) begin
      $display("%0t: flow_hash expected %h actual %h", $time, want.flow_hash, got.flow_hash);
      fail_count_o++;
    end
    if (got.packet_total !== want.packet_total) begin
      $display("%0t: packet_total expected %0d actual %0d", $time, want.packet_total,
               got.packet_total);
      fail_count_o++;
    end
    if (got.byte_total !== want.byte_total) begin
      $display("%0t: byte_total expected %0d actual %0d", $time, want.byte_total,
               got.byte_total);
      fail_count_o++;
    end
    if (got.start_time !== want.start_time) begin
      $display("%0t: start_time expected %h actual %h", $time, want.start_time,
               got.start_time);
      fail_count_o++;
    end
    if (got.end_time !== want.end_time) begin
      $display("%0t: end_time expected %h actual %h", $time, want.end_time, got.end_time);
      fail_count_o++;
    end
    if (got.flag_union !== want.flag_union) begin
      $display("%0t: flag_union expected %h actual %h", $time, want.flag_union,
               got.flag_union);
      fail_count_o++;
    end
    if (got.tos_union !== want.tos_union) begin
      $display("%0t: tos_union expected %h actual %h", $time, want.tos_union, got.tos_union);
      fail_count_o++;
    end
    if (got.icmp_union !== want.icmp_union) begin
      $display("%0t: icmp_union expected %h actual %h", $time, want.icmp_union,
               got.icmp_union);
      fail_count_o++;
    end
    if (got.lowest_ttl !== want.lowest_ttl) begin
      $display("%0t: lowest_ttl expected %0d actual %0d", $time, want.lowest_ttl,
               got.lowest_ttl);
      fail_count_o++;
    end
    if (got.highest_ttl !== want.highest_ttl) begin
      $display("%0t: highest_ttl expected %0d actual %0d", $time, want.highest_ttl,
               got.highest_ttl);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    fill[0] = 0;
    fill[1] = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_mon.valid && res_mon.ready) begin
      compare_result('{res_mon.status, res_mon.flow_hash, res_mon.packet_total,
                       res_mon.byte_total, res_mon.start_time, res_mon.end_time,
                       res_mon.flag_union, res_mon.tos_union, res_mon.icmp_union,
                       res_mon.lowest_ttl, res_mon.highest_ttl});
    end
    if (rst_ni && pkt_mon.valid && pkt_mon.ready) begin
      meter_packet('{pkt_mon.src_addr, pkt_mon.dst_addr, pkt_mon.src_port, pkt_mon.dst_port,
                     pkt_mon.protocol, pkt_mon.packet_length, pkt_mon.tcp_flag_bits,
                     pkt_mon.type_of_service, pkt_mon.icmp_mix, pkt_mon.time_to_live,
                     pkt_mon.direction, pkt_mon.timestamp});
    end
  end
endmodule

// ===== test/flow_metering_table_tb.sv =====
// ----------------------------------------------------------------------------
// Flow metering table testbench
// Drives directed and random packet words with random gaps and stalls,
// fills the egress table to overflow, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module flow_metering_table_tb;
  import fmt_pkg::*;

  localparam int unsigned Entries = 256;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;

  fmt_pkt_if pkt_ch ();
  fmt_res_if res_ch ();

  flow_metering_table #(.EntriesPerDir(Entries)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pkt_i (pkt_ch.sink),
    .res_o (res_ch.source)
  );

  fmt_checker #(.EntriesPerDir(Entries)) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_mon     (pkt_ch.sink),
    .res_mon     (res_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  pkt_t flow_pool [16];
  logic [63:0] clock_ns;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic pkt_t random_pkt();
    pkt_t p;
    p = {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
         8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
         $urandom, $urandom};
    return p;
  endfunction

  task automatic send_word(pkt_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    pkt_ch.valid <= 1'b1;
    {pkt_ch.src_addr, pkt_ch.dst_addr, pkt_ch.src_port, pkt_ch.dst_port, pkt_ch.protocol,
     pkt_ch.packet_length, pkt_ch.tcp_flag_bits, pkt_ch.type_of_service, pkt_ch.icmp_mix,
     pkt_ch.time_to_live, pkt_ch.direction, pkt_ch.timestamp} <= p;
    @(posedge clk_i);
    while (!pkt_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    pkt_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  always @(posedge clk_i) begin
    int g;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      g = gap_len();
      res_ch.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    pkt_t p;
    int k;
    pkt_ch.valid = 1'b0;
    {pkt_ch.src_addr, pkt_ch.dst_addr, pkt_ch.src_port, pkt_ch.dst_port, pkt_ch.protocol,
     pkt_ch.packet_length, pkt_ch.tcp_flag_bits, pkt_ch.type_of_service, pkt_ch.icmp_mix,
     pkt_ch.time_to_live, pkt_ch.direction, pkt_ch.timestamp} = '0;
    res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A flow at the field extremes, then updates that widen its TTL range upward.
    p = '0;
    send_word(p);
    p.time_to_live = 8'd100;
    send_word(p);
    p.time_to_live = 8'd0;
    p.packet_length = 16'hffff;
    send_word(p);
    p.time_to_live = 8'd255;
    p.tcp_flag_bits = 8'h02;
    p.type_of_service = 8'h10;
    p.icmp_mix = 8'h08;
    send_word(p);
    p = '1;
    send_word(p);
    p.direction = 1'b0;
    p.timestamp = 64'd5;
    send_word(p);
    send_word(p);
    // Two tuples with the same hash: the address terms are unchanged when an
    // address moves by 2^31 since both address constants are even.
    p = random_pkt();
    p.direction = 1'b0;
    send_word(p);
    p.src_addr ^= 32'h8000_0000;
    p.dst_addr ^= 32'h8000_0000;
    p.src_port = ~p.src_port;
    send_word(p);
    p.src_port = ~p.src_port;
    send_word(p);
    // Large lengths on one flow to push the byte count upward.
    p = random_pkt();
    for (int i = 0; i < 6; i++) begin
      p.packet_length = 16'(16'hffff - i);
      p.tcp_flag_bits = 8'(1 << i);
      send_word(p);
    end

    drain_results();

    // Fill the egress table to overflow; ingress keeps room for the random part.
    for (int i = 0; i < Entries + 8; i++) begin
      p = random_pkt();
      p.direction = 1'b1;
      send_word(p);
      if (i == 40) drain_results();
    end

    for (int i = 0; i < 16; i++) flow_pool[i] = random_pkt();
    clock_ns = 64'd1000;
    for (int i = 0; i < 170; i++) begin
      k = $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 7) begin
        p = flow_pool[k];
        p.packet_length = 16'($urandom);
        p.tcp_flag_bits = 8'($urandom);
        p.type_of_service = 8'($urandom);
        p.icmp_mix = 8'($urandom);
        p.time_to_live = 8'($urandom);
        clock_ns += 64'($urandom_range(1, 5000));
        p.timestamp = clock_ns;
        if ($urandom_range(0, 3) == 0) p.direction = 1'b1;
      end else begin
        p = random_pkt();
      end
      send_word(p);
    end

    drain_results();
    repeat (Entries + 40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
